[src/rtsp_pkg.sv]
package rtsp_pkg;

	localparam int DEF_MAX_NODES = 1024;
	localparam int DEF_MAX_EDGES = 4096;

	localparam int NODE_W   = 11;
	localparam int WEIGHT_W = 16;
	localparam int SUM_W    = 28;
	localparam int DIST_W   = 32;
	localparam int EDGE_W   = 2 * NODE_W + WEIGHT_W;

	localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

	localparam logic REG_NODE_COUNT   = 1'b0;
	localparam logic REG_MEETING_NODE = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,
		S_SRC,
		S_ERD,
		S_DRD,
		S_RLX,
		S_FRD,
		S_FACC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              we;
		logic [DIST_W-1:0] wdata;
	} dist_wr_t;

endpackage

[src/rtsp_edge_mem.sv]
module rtsp_edge_mem #(
	parameter int AW = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [rtsp_pkg::EDGE_W-1:0] wdata,
	input  logic [AW-1:0]            raddr,
	output logic [rtsp_pkg::EDGE_W-1:0] rdata
);
	import rtsp_pkg::*;

	logic [EDGE_W-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/rtsp_dist_mem.sv]
module rtsp_dist_mem #(
	parameter int AW = 10
) (
	input  logic                        clk,
	input  rtsp_pkg::dist_wr_t          wr,
	input  logic [AW-1:0]               waddr,
	input  logic [AW-1:0]               raddr_a,
	input  logic [AW-1:0]               raddr_b,
	output logic [rtsp_pkg::DIST_W-1:0] rdata_a,
	output logic [rtsp_pkg::DIST_W-1:0] rdata_b
);
	import rtsp_pkg::*;

	logic [DIST_W-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[waddr] <= wr.wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[src/round_trip_shortest_path_max_top.sv]
// Round-trip shortest path maximum. Edges are loaded one per beat into an edge store of
// MAX_EDGES entries (extra edges are dropped). The beat with last_edge set starts the
// search and in_ready stays low until it ends: first both distance tables are set to
// infinity for each of the node_count nodes, then relaxation passes run over the stored
// edges, each edge going through the S_ERD, S_DRD and S_RLX states and one shared add
// and compare unit, repeated until a pass changes nothing, first over the forward edges
// and then over the reversed ones, and last a sweep through S_FRD and S_FACC for each
// node forms the largest go plus back sum. The result sits in an output register, so
// loading of the next batch may start while it waits.
module round_trip_shortest_path_max_top #(
	parameter int MAX_NODES = rtsp_pkg::DEF_MAX_NODES,
	parameter int MAX_EDGES = rtsp_pkg::DEF_MAX_EDGES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_addr,
	input  logic [rtsp_pkg::NODE_W-1:0]  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rtsp_pkg::NODE_W-1:0]  from_node,
	input  logic [rtsp_pkg::NODE_W-1:0]  to_node,
	input  logic [rtsp_pkg::WEIGHT_W-1:0] edge_weight,
	input  logic                         last_edge,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rtsp_pkg::SUM_W-1:0]   max_round_trip,
	output logic                         all_reachable
);
	import rtsp_pkg::*;

	localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int NCW = $clog2(MAX_NODES + 1);

	state_t state_q, state_d;
	logic [NODE_W-1:0] node_count_q, meeting_node_q;
	logic [ECW-1:0]    cnt_q, cnt_d;
	logic [EAW-1:0]    e_q, e_d;
	logic [NCW-1:0]    i_q, i_d;
	logic              rev_q, rev_d, chg_q, chg_d;
	logic [SUM_W-1:0]  best_q, best_d, max_q, max_d;
	logic              all_q, all_d, allr_q, allr_d, ov_q, ov_d;

	logic [NCW-1:0]    n_eff;
	logic [EDGE_W-1:0] edge_rd;
	logic [NODE_W-1:0] e_from, e_to, a_node, b_node;
	logic [WEIGHT_W-1:0] e_w;
	logic              e_ok, s_ok, relax;
	logic [NAW-1:0]    ra, rb, waddr, s_idx;
	logic [DIST_W-1:0] go_a, go_b, bk_a, bk_b, da, db, ndc;
	logic [DIST_W:0]   nd, sum;
	logic [SUM_W-1:0]  t_sum;
	dist_wr_t          go_wr, bk_wr;
	logic              in_acc, edge_we;

	always_comb begin
		if (node_count_q == '0) begin
			n_eff = NCW'(1);
		end else if (32'(node_count_q) > 32'(MAX_NODES)) begin
			n_eff = NCW'(MAX_NODES);
		end else begin
			n_eff = NCW'(node_count_q);
		end
	end

	assign s_ok  = (meeting_node_q != '0) && (32'(meeting_node_q) <= 32'(n_eff));
	assign s_idx = NAW'(meeting_node_q - NODE_W'(1));

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign edge_we  = in_acc && (32'(cnt_q) < 32'(MAX_EDGES));

	rtsp_edge_mem #(.AW(EAW)) u_edge (
		.clk   (clk),
		.we    (edge_we),
		.waddr (EAW'(cnt_q)),
		.wdata ({from_node, to_node, edge_weight}),
		.raddr (e_q),
		.rdata (edge_rd)
	);

	assign e_from = edge_rd[EDGE_W-1 -: NODE_W];
	assign e_to   = edge_rd[WEIGHT_W +: NODE_W];
	assign e_w    = edge_rd[WEIGHT_W-1:0];
	assign a_node = rev_q ? e_to : e_from;
	assign b_node = rev_q ? e_from : e_to;
	assign e_ok   = (a_node != '0) && (32'(a_node) <= 32'(n_eff))
		&& (b_node != '0) && (32'(b_node) <= 32'(n_eff));

	assign ra = (state_q == S_FRD || state_q == S_FACC) ? NAW'(i_q)
		: NAW'(a_node - NODE_W'(1));
	assign rb = NAW'(b_node - NODE_W'(1));

	// shared relax unit
	assign da    = rev_q ? bk_a : go_a;
	assign db    = rev_q ? bk_b : go_b;
	assign nd    = {1'b0, da} + (DIST_W+1)'(e_w);
	assign ndc   = (nd >= (DIST_W+1)'(DIST_INF)) ? (DIST_INF - DIST_W'(1)) : nd[DIST_W-1:0];
	assign relax = e_ok && (da != DIST_INF) && (ndc < db);

	assign sum   = {1'b0, go_a} + {1'b0, bk_a};
	assign t_sum = (sum > (DIST_W+1)'(SUM_MAX)) ? SUM_MAX : sum[SUM_W-1:0];

	always_comb begin
		go_wr = '{we: 1'b0, wdata: DIST_INF};
		bk_wr = '{we: 1'b0, wdata: DIST_INF};
		waddr = NAW'(i_q);
		case (state_q)
			S_CLR: begin
				go_wr.we = 1'b1;
				bk_wr.we = 1'b1;
			end
			S_SRC: begin
				waddr       = s_idx;
				go_wr       = '{we: s_ok, wdata: '0};
				bk_wr       = '{we: s_ok, wdata: '0};
			end
			S_RLX: begin
				waddr = rb;
				go_wr = '{we: relax && !rev_q, wdata: ndc};
				bk_wr = '{we: relax && rev_q, wdata: ndc};
			end
			default: begin
			end
		endcase
	end

	rtsp_dist_mem #(.AW(NAW)) u_go (
		.clk     (clk),
		.wr      (go_wr),
		.waddr   (waddr),
		.raddr_a (ra),
		.raddr_b (rb),
		.rdata_a (go_a),
		.rdata_b (go_b)
	);

	rtsp_dist_mem #(.AW(NAW)) u_back (
		.clk     (clk),
		.wr      (bk_wr),
		.waddr   (waddr),
		.raddr_a (ra),
		.raddr_b (rb),
		.rdata_a (bk_a),
		.rdata_b (bk_b)
	);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		e_d     = e_q;
		i_d     = i_q;
		rev_d   = rev_q;
		chg_d   = chg_q;
		best_d  = best_q;
		all_d   = all_q;
		max_d   = max_q;
		allr_d  = allr_q;
		ov_d    = ov_q && !out_ready;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (edge_we) begin
						cnt_d = cnt_q + ECW'(1);
					end
					if (last_edge) begin
						i_d     = '0;
						state_d = S_CLR;
					end
				end
			end
			S_CLR: begin
				if (i_q == n_eff - NCW'(1)) begin
					state_d = S_SRC;
				end else begin
					i_d = i_q + NCW'(1);
				end
			end
			S_SRC: begin
				e_d     = '0;
				rev_d   = 1'b0;
				chg_d   = 1'b0;
				state_d = S_ERD;
			end
			S_ERD: state_d = S_DRD;
			S_DRD: state_d = S_RLX;
			S_RLX: begin
				chg_d = chg_q || relax;
				if (32'(e_q) == 32'(cnt_q) - 1) begin
					e_d = '0;
					if (chg_q || relax) begin
						chg_d   = 1'b0;
						state_d = S_ERD;
					end else if (!rev_q) begin
						rev_d   = 1'b1;
						chg_d   = 1'b0;
						state_d = S_ERD;
					end else begin
						i_d     = '0;
						best_d  = '0;
						all_d   = 1'b1;
						state_d = S_FRD;
					end
				end else begin
					e_d     = e_q + EAW'(1);
					state_d = S_ERD;
				end
			end
			S_FRD: state_d = S_FACC;
			S_FACC: begin
				if (go_a != DIST_INF && bk_a != DIST_INF) begin
					if (t_sum > best_q) begin
						best_d = t_sum;
					end
				end else begin
					all_d = 1'b0;
				end
				if (i_q == n_eff - NCW'(1)) begin
					state_d = S_DONE;
				end else begin
					i_d     = i_q + NCW'(1);
					state_d = S_FRD;
				end
			end
			S_DONE: begin
				if (!ov_q) begin
					max_d   = best_q;
					allr_d  = all_q;
					ov_d    = 1'b1;
					cnt_d   = '0;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			node_count_q   <= NODE_W'(1);
			meeting_node_q <= NODE_W'(1);
			cnt_q          <= '0;
			e_q            <= '0;
			i_q            <= '0;
			rev_q          <= 1'b0;
			chg_q          <= 1'b0;
			ov_q           <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			e_q     <= e_d;
			i_q     <= i_d;
			rev_q   <= rev_d;
			chg_q   <= chg_d;
			ov_q    <= ov_d;
			if (cfg_we) begin
				case (cfg_addr)
					REG_NODE_COUNT:   node_count_q   <= cfg_wdata;
					REG_MEETING_NODE: meeting_node_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		best_q <= best_d;
		all_q  <= all_d;
		max_q  <= max_d;
		allr_q <= allr_d;
	end

	assign out_valid      = ov_q;
	assign max_round_trip = max_q;
	assign all_reachable  = allr_q;

endmodule

[src/rtsp_checker.sv]
module rtsp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        last_edge,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [rtsp_pkg::SUM_W-1:0]  max_round_trip,
	input logic                        all_reachable
);
	import rtsp_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(max_round_trip)
			&& $stable(all_reachable))
		else $error("result changed while stalled");

	// a last beat starts the search and blocks input
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_edge |=> !in_ready && !$rose(out_valid))
		else $error("input not blocked after last beat");

	// a fresh result comes with the input reopened
	a_done_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown while search busy");

endmodule

bind round_trip_shortest_path_max_top rtsp_checker u_rtsp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.last_edge      (last_edge),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.max_round_trip (max_round_trip),
	.all_reachable  (all_reachable)
);
